// ===== sv/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants of the histogram bar scaler
// Command codes, fixed payload widths and the divider status bundle.
// ----------------------------------------------------------------------------
package hbs_pkg;

  typedef enum logic [1:0] {
    CMD_ACCUMULATE = 2'd0,
    CMD_READ       = 2'd1,
    CMD_CLEAR      = 2'd2
  } hbs_cmd_t;

  localparam int CMD_W       = 2;
  localparam int LEVEL_W     = 8;
  localparam int COUNT_OUT_W = 24;
  localparam int BAR_W       = 7;
  localparam int BAR_SCALE   = 100;

  // Status of the bar-height divider as seen by the control logic.
  typedef struct packed {
    logic busy;
    logic done;
  } hbs_div_stat_t;

endpackage

// ===== sv/hbs_if.sv =====
// ----------------------------------------------------------------------------
// hbs_if: stream channels of the histogram bar scaler
// Command channel and result channel, each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface hbs_in_if import hbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] bin_index;

  modport source (output valid, output cmd, output red_level, output bin_index,
                  input ready);
  modport sink   (input valid, input cmd, input red_level, input bin_index,
                  output ready);
endinterface

interface hbs_out_if import hbs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [LEVEL_W-1:0]     bin_echo;
  logic [COUNT_OUT_W-1:0] bin_count;
  logic [BAR_W-1:0]       bar_height;
  logic [COUNT_OUT_W-1:0] peak_count;

  modport source (output valid, output bin_echo, output bin_count,
                  output bar_height, output peak_count, input ready);
  modport sink   (input valid, input bin_echo, input bin_count,
                  input bar_height, input peak_count, output ready);
endinterface

// ===== sv/hbs_bar_div.sv =====
// ----------------------------------------------------------------------------
// hbs_bar_div: bar-height divider
// Computes floor(count * 100 / peak) one quotient bit per cycle, or 0 when
// the peak is zero. The result is held until the control logic takes it.
// ----------------------------------------------------------------------------
module hbs_bar_div import hbs_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [COUNT_WIDTH-1:0] peak,
  input  logic                   take,
  output hbs_div_stat_t          stat,
  output logic [BAR_W-1:0]       quot
);

  // The numerator needs seven extra bits for the factor of 100.
  localparam int NW = COUNT_WIDTH + BAR_W;
  localparam int SW = $clog2(BAR_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } div_state_t;

  div_state_t       state_r;
  logic [NW-1:0]    rem_r;
  logic [NW-1:0]    div_r;
  logic [SW-1:0]    step_r;
  logic [BAR_W-1:0] q_r;
  logic             zero_r;

  logic [NW-1:0]    num;
  logic [NW-1:0]    trial;
  logic             fits;

  // count * 100 as shifts and adds: 64 + 32 + 4.
  assign num   = (NW'(count) << 6) + (NW'(count) << 5) + (NW'(count) << 2);
  assign trial = div_r << step_r;
  assign fits  = rem_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            rem_r   <= num;
            div_r   <= NW'(peak);
            step_r  <= SW'(BAR_W - 1);
            q_r     <= '0;
            zero_r  <= (peak == '0);
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (fits) begin
            rem_r       <= rem_r - trial;
            q_r[step_r] <= 1'b1;
          end
          if (step_r == '0) begin
            state_r <= S_DONE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign quot      = zero_r ? '0 : q_r;

endmodule

// ===== sv/histogram_bar_scaler_top.sv =====
// ----------------------------------------------------------------------------
// histogram_bar_scaler_top: red-level histogram with bar-height read-out
// Flow: an accumulate beat is absorbed at one per cycle unless input is held
//   off; a read beat holds off input until its result has moved to the
//   output register.
// Throughput: one accumulate per cycle while input is not held off, set by the
//   one-read, one-write bin memory read/modify/write loop; reads are bounded
//   by the 7-step bit-serial divider.
// Reset and clear: a sweep zeroes the bin memory one entry per cycle, over all
//   BINS entries, during which no input beat is accepted.
// ----------------------------------------------------------------------------
module histogram_bar_scaler_top import hbs_pkg::*; #(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  hbs_in_if.sink    in_ch,
  hbs_out_if.source out_ch
);

  localparam int                     AW        = $clog2(BINS);
  localparam logic [31:0]            BINS_W    = 32'(BINS);
  localparam logic [AW-1:0]          LAST_BIN  = AW'(BINS - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

  // The bin counts live in one synchronous memory with a registered read.
  logic [COUNT_WIDTH-1:0] bin_mem [BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;

  // Clearing sweep.
  logic          sweep_r;
  logic [AW-1:0] sweep_idx_r;

  // Second stage: the beat whose memory data has just arrived.
  logic          s1_valid_r;
  logic          s1_is_read_r;
  logic          s1_hit_r;
  logic [AW-1:0] s1_addr_r;
  logic [LEVEL_W-1:0] s1_echo_r;

  // Last value written back, for a back-to-back beat on the same bin.
  logic                   fwd_valid_r;
  logic [AW-1:0]          fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  logic [COUNT_WIDTH-1:0] peak_r;
  logic [COUNT_WIDTH-1:0] peak_nxt;

  // Fields of the read in progress, held while the divider works.
  logic [LEVEL_W-1:0]     res_echo_r;
  logic [COUNT_WIDTH-1:0] res_count_r;
  logic [COUNT_WIDTH-1:0] res_peak_r;

  // Output register.
  logic                   out_valid_r;
  logic [LEVEL_W-1:0]     out_echo_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  logic [BAR_W-1:0]       out_bar_r;
  logic [COUNT_OUT_W-1:0] out_peak_r;

  logic                   in_ready;
  logic                   fire;
  logic                   cmd_acc;
  logic                   cmd_read;
  logic                   cmd_clear;
  logic [31:0]            sel32;
  logic [AW-1:0]          rd_addr;
  logic                   rd_hit;
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] inc_count;
  logic                   acc_wr;
  logic                   div_start;
  logic [COUNT_WIDTH-1:0] read_count;
  hbs_div_stat_t          div_stat;
  logic [BAR_W-1:0]       div_quot;
  logic                   out_load;
  logic [31:0]            res_count32;
  logic [31:0]            res_peak32;

  // Input is held off during the sweep, while a read waits for or occupies
  // the divider, and until the divider's result has moved to the output
  // register. Accumulate beats only touch memory and peak, so a result still
  // waiting at the output does not stop them.
  assign in_ready    = !sweep_r && !div_stat.busy && !(s1_valid_r && s1_is_read_r);
  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid && in_ready;

  assign cmd_acc   = (in_ch.cmd == CMD_ACCUMULATE);
  assign cmd_read  = (in_ch.cmd == CMD_READ);
  assign cmd_clear = (in_ch.cmd == CMD_CLEAR);

  // A read uses the bin index, an accumulate the red level. Either may lie
  // beyond the bins when BINS is below 256; such a beat misses the memory.
  assign sel32   = cmd_read ? 32'(in_ch.bin_index) : 32'(in_ch.red_level);
  assign rd_addr = sel32[AW-1:0];
  assign rd_hit  = (sel32 < BINS_W);

  // The memory read issued at acceptance coincides with the write-back of the
  // previous beat and therefore returns the old value; the forwarding register
  // supplies the new one. Older writes are already visible in the memory.
  assign cur_count = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r
                                                                : rd_data_r;
  assign inc_count = (cur_count == COUNT_TOP) ? cur_count : cur_count + 1'b1;
  assign acc_wr    = s1_valid_r && !s1_is_read_r && s1_hit_r;

  assign div_start  = s1_valid_r && s1_is_read_r;
  assign read_count = s1_hit_r ? cur_count : '0;

  // Counts only grow, so the running peak is the largest bin. A clear taken
  // in the same cycle as a write-back comes later in order and wins.
  always_comb begin
    peak_nxt = peak_r;
    if (fire && cmd_clear) begin
      peak_nxt = '0;
    end else if (acc_wr && (inc_count > peak_r)) begin
      peak_nxt = inc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      bin_mem[sweep_idx_r] <= '0;
    end else if (acc_wr) begin
      bin_mem[s1_addr_r] <= inc_count;
    end
    rd_data_r <= bin_mem[rd_addr];
  end

  // The sweep starts at reset and on a clear beat. Any accumulate still in the
  // second stage writes back in the cycle of the clear, before the sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_idx_r <= '0;
    end else if (fire && cmd_clear) begin
      sweep_r     <= 1'b1;
      sweep_idx_r <= '0;
    end else if (sweep_r) begin
      if (sweep_idx_r == LAST_BIN) begin
        sweep_r <= 1'b0;
      end else begin
        sweep_idx_r <= sweep_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      s1_valid_r <= fire && (cmd_acc || cmd_read);
      peak_r     <= peak_nxt;
      if (sweep_r) begin
        fwd_valid_r <= 1'b0;
      end else if (acc_wr) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_is_read_r <= cmd_read;
      s1_hit_r     <= rd_hit;
      s1_addr_r    <= rd_addr;
      s1_echo_r    <= in_ch.bin_index;
    end
    if (acc_wr) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= inc_count;
    end
    if (div_start) begin
      res_echo_r  <= s1_echo_r;
      res_count_r <= read_count;
      res_peak_r  <= peak_r;
    end
  end

  hbs_bar_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .count (read_count),
    .peak  (peak_r),
    .take  (out_load),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // The finished result moves to the output register once it is free or its
  // beat is being taken; until then the divider holds it.
  assign out_load    = div_stat.done && (!out_valid_r || out_ch.ready);
  assign res_count32 = 32'(res_count_r);
  assign res_peak32  = 32'(res_peak_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_echo_r  <= res_echo_r;
      out_count_r <= res_count32[COUNT_OUT_W-1:0];
      out_bar_r   <= div_quot;
      out_peak_r  <= res_peak32[COUNT_OUT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_echo   = out_echo_r;
  assign out_ch.bin_count  = out_count_r;
  assign out_ch.bar_height = out_bar_r;
  assign out_ch.peak_count = out_peak_r;

endmodule
